@@ src/assert_macros.svh @@
// Assertion macros used by the divider RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define FDR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`endif

@@ src/fdr_pkg.sv @@
// Types and constants of the table-reciprocal divider.
package fdr_pkg;

   localparam int unsigned WORD_W  = 32;
   localparam int unsigned IDX_W   = 10;
   localparam int unsigned BASE_W  = 23;
   localparam int unsigned SLOPE_W = 13;
   localparam int unsigned ENTRY_W = BASE_W + SLOPE_W;
   localparam int unsigned MANT_W  = 23;
   localparam int unsigned EXP_W   = 8;

   typedef enum logic {
      OP_DIVIDE = 1'b0,
      OP_LOAD   = 1'b1
   } op_type;

   // Stage that carries a divide while its table entry is read.
   typedef struct packed {
      logic                  valid;
      logic                  sign;
      logic [EXP_W-1:0]      exponent;
      logic [MANT_W-1:0]     mantissa;
      logic [WORD_W-1:0]     dividend;
   } lookup_type;

   // Stage that carries the dividend and the divisor reciprocal.
   typedef struct packed {
      logic                  valid;
      logic [WORD_W-1:0]     dividend;
      logic [WORD_W-1:0]     recip;
   } recip_type;

endpackage

@@ src/fdr_if.sv @@
// Valid/ready channels of the divider.
interface fdr_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [31:0] dividend;
   logic [31:0] divisor;
   logic [9:0]  table_index;
   logic [22:0] table_base;
   logic [12:0] table_slope;
   modport source (output valid, operation, dividend, divisor, table_index, table_base,
                   table_slope, input ready);
   modport sink   (input valid, operation, dividend, divisor, table_index, table_base,
                   table_slope, output ready);
endinterface

interface fdr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] quotient;
   modport source (output valid, quotient, input ready);
   modport sink   (input valid, quotient, output ready);
endinterface

@@ src/float_divide_reciprocal_table.sv @@
// A divide's quotient passes the table read and the reciprocal, product and result registers.
// Throughput: one operation per cycle; the table RAM port serves one load or one lookup a cycle.
// A load writes one table entry and yields no quotient.
// The pipeline stalls as a whole while a quotient waits on the result channel.
// Synchronous reset clears the stage valid bits; table contents stay undefined until loaded.
`include "assert_macros.svh"
module float_divide_reciprocal_table #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   fdr_req_if.sink    req,
   fdr_rsp_if.source  rsp
);
   import fdr_pkg::*;

   localparam int unsigned ADDR_W = $clog2(TABLE_DEPTH);

   logic                 advance;
   logic                 req_xfer;
   logic                 load_xfer;
   logic                 divide_xfer;
   logic [ADDR_W-1:0]    ram_addr;
   logic [ENTRY_W-1:0]   entry;
   lookup_type           lookup_ff;
   recip_type            recip_st;

   // Stall everything while the result is held
   assign advance     = !rsp.valid || rsp.ready;
   assign req.ready   = advance;
   assign req_xfer    = req.valid && advance;
   assign load_xfer   = req_xfer && (req.operation == OP_LOAD);
   assign divide_xfer = req_xfer && (req.operation == OP_DIVIDE);
   assign ram_addr    = (req.operation == OP_LOAD) ? req.table_index[ADDR_W-1:0]
                                                   : req.divisor[22:22-ADDR_W+1];

   fdr_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock      (clock),
      .write_en   (load_xfer),
      .read_en    (divide_xfer),
      .addr       (ram_addr),
      .write_data ({req.table_base, req.table_slope}),
      .read_data  (entry)
   );

   // Hold divisor fields alongside the table read
   always_ff @(posedge clock) begin
      if (reset) begin
         lookup_ff.valid <= 1'b0;
      end else if (advance) begin
         lookup_ff.valid <= req.valid && (req.operation == OP_DIVIDE);
      end
      if (advance) begin
         lookup_ff.sign     <= req.divisor[31];
         lookup_ff.exponent <= req.divisor[30:23];
         lookup_ff.mantissa <= req.divisor[22:0];
         lookup_ff.dividend <= req.dividend;
      end
   end

   fdr_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .lookup    (lookup_ff),
      .entry     (entry),
      .recip_out (recip_st)
   );

   fdr_mul u_mul (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .recip_in   (recip_st),
      .quot_valid (rsp.valid),
      .quotient   (rsp.quotient)
   );

   `FDR_ASSERT(a_stall_blocks_req, rsp.valid && !rsp.ready |-> !req.ready, "req taken in stall")
   `FDR_ASSERT(a_load_no_lookup, load_xfer |=> !lookup_ff.valid, "load entered divide path")
   `FDR_ASSERT(a_divide_enters, divide_xfer |=> lookup_ff.valid, "divide lost at entry")
endmodule

@@ src/fdr_ram.sv @@
// Generic single-port RAM with registered read.
module fdr_ram #(
   parameter int unsigned WIDTH = 36,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic                     read_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // Write or read one entry per cycle
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[addr];
      end
   end

   assign read_data = read_data_ff;
endmodule

@@ src/fdr_recip.sv @@
// Reciprocal stage: interpolate the table entry and form the reciprocal word.
module fdr_recip (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  fdr_pkg::lookup_type             lookup,
   input  logic [fdr_pkg::ENTRY_W-1:0]     entry,
   output fdr_pkg::recip_type              recip_out
);
   import fdr_pkg::*;

   logic [BASE_W-1:0]        base;
   logic [SLOPE_W-1:0]       slope;
   logic [SLOPE_W-1:0]       low;
   logic [2*SLOPE_W-1:0]     slope_prod;
   logic [ENTRY_W-1:0]       interp;
   logic [EXP_W-1:0]         exp_bias;
   logic [EXP_W-1:0]         recip_exp;
   recip_type                recip_in;
   recip_type                recip_ff;

   // Interpolate 2^35 + base<<12 - slope*low13
   always_comb begin
      base       = entry[ENTRY_W-1:SLOPE_W];
      slope      = entry[SLOPE_W-1:0];
      low        = lookup.mantissa[SLOPE_W-1:0];
      slope_prod = slope * low;
      interp     = {1'b1, {(ENTRY_W-1){1'b0}}} + {1'b0, base, 12'd0}
                   - {{(ENTRY_W-2*SLOPE_W){1'b0}}, slope_prod};
      exp_bias   = (lookup.mantissa != '0) ? EXP_W'(2) : EXP_W'(1);
      recip_exp  = ~(lookup.exponent + exp_bias);
      recip_in.valid    = lookup.valid;
      recip_in.dividend = lookup.dividend;
      recip_in.recip    = {lookup.sign, recip_exp, interp[34:12]};
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         recip_ff.valid <= 1'b0;
      end else if (advance) begin
         recip_ff.valid <= recip_in.valid;
      end
      if (advance) begin
         recip_ff.dividend <= recip_in.dividend;
         recip_ff.recip    <= recip_in.recip;
      end
   end

   assign recip_out = recip_ff;
endmodule

@@ src/fdr_mul.sv @@
// Multiply stage: mantissa product, then normalize, round and pack.
module fdr_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  fdr_pkg::recip_type           recip_in,
   output logic                         quot_valid,
   output logic [fdr_pkg::WORD_W-1:0]   quotient
);
   import fdr_pkg::*;

   logic                   prod_valid_ff;
   logic                   prod_sign_ff;
   logic [EXP_W-1:0]       exp_a_ff;
   logic [EXP_W-1:0]       exp_b_ff;
   logic [47:0]            prod_ff;
   logic [47:0]            prod_in;
   logic [8:0]             esum;
   logic [25:0]            top;
   logic                   hi;
   logic [23:0]            keep;
   logic [MANT_W-1:0]      mant_y;
   logic [8:0]             exp_y;
   logic [WORD_W-1:0]      quot_in;
   logic                   quot_valid_ff;
   logic [WORD_W-1:0]      quot_ff;

   assign prod_in = {24'd0, 1'b1, recip_in.dividend[22:0]} * {24'd0, 1'b1, recip_in.recip[22:0]};

   // Normalize, round by the next bit, pack
   always_comb begin
      esum   = {1'b0, exp_a_ff} + {1'b0, exp_b_ff} - 9'd127;
      top    = prod_ff[47:22];
      hi     = top[25];
      keep   = hi ? top[24:1] : top[23:0];
      mant_y = keep[23:1] + {22'd0, keep[0]};
      exp_y  = (hi || (top[23:0] == 24'hFFFFFF)) ? esum + 9'd1 : esum;
      if ((exp_a_ff != '0) && (exp_b_ff != '0)) begin
         quot_in = {prod_sign_ff, exp_y[7:0], mant_y};
      end else begin
         quot_in = {prod_sign_ff, 31'd0};
      end
   end

   // Advance product and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= recip_in.valid;
         quot_valid_ff <= prod_valid_ff;
      end
      if (advance) begin
         prod_ff      <= prod_in;
         prod_sign_ff <= recip_in.dividend[31] ^ recip_in.recip[31];
         exp_a_ff     <= recip_in.dividend[30:23];
         exp_b_ff     <= recip_in.recip[30:23];
         quot_ff      <= quot_in;
      end
   end

   assign quot_valid = quot_valid_ff;
   assign quotient   = quot_ff;
endmodule

@@ bench/tb_fdr_if.sv @@
// Bench-side note: the channel interfaces come from the RTL source (fdr_if.sv).
// This file holds the bench's own transfer record type used by the driver in tb_top.
package tb_fdr_pkg;
   import fdr_pkg::*;

   // One request transfer as the driver presents it.
   typedef struct packed {
      op_type      operation;
      logic [31:0] dividend;
      logic [31:0] divisor;
      logic [9:0]  table_index;
      logic [22:0] table_base;
      logic [12:0] table_slope;
   } div_item_type;
endpackage

@@ bench/tb_top.sv @@
// Bench for the table-reciprocal divider: predicts each quotient and checks it.
module tb_top;
   import fdr_pkg::*;
   import tb_fdr_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 20;
   localparam int TABLE_DEPTH_C = 1024;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fdr_req_if req ();
   fdr_rsp_if rsp ();

   float_divide_reciprocal_table dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   always #5 clock = ~clock;

   div_item_type pending_items[$];
   logic [31:0]  expected_quotients[$];
   logic [35:0]  recip_rom[TABLE_DEPTH_C];
   logic         entry_loaded[TABLE_DEPTH_C];
   int           req_idle_pct = 31;
   int           rsp_idle_pct = 82;
   int           hold_off_cycles = 0;
   int           error_count = 0;
   int           cycle_count = 0;
   bit           stimulus_done = 1'b0;

   // Reciprocal of the divisor from the predicted table.
   function automatic logic [31:0] table_reciprocal(logic [31:0] x);
      logic [9:0]  idx;
      logic [12:0] low;
      logic [35:0] entry;
      logic [7:0]  ey;
      logic [35:0] val;
      idx   = x[22:13];
      low   = x[12:0];
      entry = recip_rom[idx];
      if (idx != 0 || low != 0) ey = ~(x[30:23] + 8'd2);
      else ey = ~(x[30:23] + 8'd1);
      val = 36'h8_0000_0000 + ({13'd0, entry[35:13]} << 12)
            - {23'd0, entry[12:0]} * {23'd0, low};
      return {x[31], ey, val[34:12]};
   endfunction

   // Multiplier model with the divider's rounding rule.
   function automatic logic [31:0] truncating_product(logic [31:0] a, logic [31:0] b);
      logic [47:0] prod;
      logic [8:0]  esum;
      logic [25:0] top;
      logic [23:0] keep;
      logic [22:0] my;
      logic [8:0]  ey;
      logic        sy;
      prod = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
      sy   = a[31] ^ b[31];
      esum = {1'b0, a[30:23]} + {1'b0, b[30:23]} - 9'd127;
      top  = prod[47:22];
      keep = top[25] ? top[24:1] : top[23:0];
      my   = keep[23:1] + {22'd0, keep[0]};
      ey   = esum;
      if (top[25] || top[23:0] == 24'hFF_FFFF) ey = ey + 9'd1;
      if (a[30:23] != 0 && b[30:23] != 0) return {sy, ey[7:0], my};
      return {sy, 31'd0};
   endfunction

   // Divisor whose table index has been loaded.
   function automatic logic [31:0] loaded_divisor();
      logic [31:0] d;
      d = $urandom;
      while (!entry_loaded[d[22:13]]) d[22:13] = 10'($urandom_range(1023));
      return d;
   endfunction

   function automatic div_item_type make_divide(logic [31:0] a, logic [31:0] d);
      div_item_type it;
      it = '0;
      it.operation = OP_DIVIDE;
      it.dividend = a;
      it.divisor = d;
      it.table_index = 10'($urandom);
      it.table_base = 23'($urandom);
      it.table_slope = 13'($urandom);
      return it;
   endfunction

   function automatic div_item_type make_load(logic [9:0] i, logic [22:0] b, logic [12:0] s);
      div_item_type it;
      it = '0;
      it.operation = OP_LOAD;
      it.dividend = $urandom;
      it.divisor = $urandom;
      it.table_index = i;
      it.table_base = b;
      it.table_slope = s;
      entry_loaded[i] = 1'b1;
      return it;
   endfunction

   // Fill the stimulus queue: directed items, then random phases.
   initial begin
      for (int i = 0; i < TABLE_DEPTH_C; i++) entry_loaded[i] = 1'b0;
      pending_items.push_back(make_load(10'd0, 23'd0, 13'd0));
      pending_items.push_back(make_load(10'd1023, 23'h7F_FFFF, 13'h1FFF));
      pending_items.push_back(make_load(10'd512, 23'h40_0000, 13'h1000));
      pending_items.push_back(make_divide(32'h3F80_0000, 32'h4000_0000));
      pending_items.push_back(make_divide(32'hBF80_0000, 32'h3F80_0000));
      pending_items.push_back(make_divide(32'h0000_0000, 32'h4000_0000));
      pending_items.push_back(make_divide(32'h8012_3456, 32'hC000_0000));
      pending_items.push_back(make_divide(32'h3F80_0000, 32'h7F80_0000));
      pending_items.push_back(make_divide(32'h3F80_0000, 32'h7F7F_FFFF));
      pending_items.push_back(make_divide(32'h7F7F_FFFF, 32'h0080_0000));
      pending_items.push_back(make_divide(32'h0080_0000, 32'h7F00_0000));
      pending_items.push_back(make_divide(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      pending_items.push_back(make_divide(32'h3FFF_FFFF, 32'h4000_1FFF));
      pending_items.push_back(make_divide(32'h7FFF_FFFF, 32'h0000_0000));
      pending_items.push_back(make_divide(32'h3FFF_FFFF, 32'h3FC0_0000));
      for (int n = 0; n < 1200; n++) begin
         if ($urandom_range(99) < 25)
            pending_items.push_back(make_load(10'($urandom), 23'($urandom), 13'($urandom)));
         else pending_items.push_back(make_divide($urandom, loaded_divisor()));
      end
      stimulus_done = 1'b1;
   end

   // Drive requests; predict the table when a load transfers, the quotient when a divide does.
   div_item_type drive_item;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req.valid <= 1'b0;
      end else if (!req.valid || req.ready) begin
         // Advance after a transfer; idle at random between items.
         if (req.valid && req.ready) begin
            if (req.operation == OP_LOAD)
               recip_rom[req.table_index] <= {req.table_base, req.table_slope};
            else
               expected_quotients.push_back(
                  truncating_product(req.dividend, table_reciprocal(req.divisor)));
         end
         if (pending_items.size() > 0 && $urandom_range(99) >= req_idle_pct) begin
            drive_item = pending_items.pop_front();
            req.valid       <= 1'b1;
            req.operation   <= drive_item.operation;
            req.dividend    <= drive_item.dividend;
            req.divisor     <= drive_item.divisor;
            req.table_index <= drive_item.table_index;
            req.table_base  <= drive_item.table_base;
            req.table_slope <= drive_item.table_slope;
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Drive ready; hold off for a long stretch when asked.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Check each quotient against the oldest prediction.
   logic [31:0] want_q;
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_quotients.size() == 0) begin
            $error("quotient with no prediction: actual %h", rsp.quotient);
            error_count++;
         end else begin
            want_q = expected_quotients.pop_front();
            if (rsp.quotient !== want_q) begin
               $error("quotient: expected %h actual %h", want_q, rsp.quotient);
               error_count++;
            end
         end
      end
   end

   // Reset, idle phases, drain and verdict.
   initial begin
      req.valid = 1'b0;
      req.operation = OP_DIVIDE;
      req.dividend = '0;
      req.divisor = '0;
      req.table_index = '0;
      req.table_base = '0;
      req.table_slope = '0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done);
      wait (pending_items.size() < 1000);
      @(posedge clock);
      hold_off_cycles <= 300;
      wait (pending_items.size() < 800);
      req_idle_pct = 82;
      rsp_idle_pct = 31;
      wait (pending_items.size() < 400);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      wait (pending_items.size() == 0 && !req.valid && expected_quotients.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_quotients.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > LIMIT_CYCLES) begin
         $display("CHECK FAILED");
         $finish;
      end
   end
endmodule
